// ===== rtl/core/mdsq_pkg.sv =====
// ----------------------------------------------------------------------------
// mdsq_pkg
// Shared sizes, entry layout and operation codes of the multilevel
// deadline-sorted queue.
// ----------------------------------------------------------------------------
package mdsq_pkg;

    localparam int LEVELS    = 4;
    localparam int DEPTH     = 8;

    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int ADDR_W    = LVL_W + SLOT_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;

    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_UPD  = 1'b1;

    typedef struct packed {
        logic [31:0] deadline;
        logic [7:0]  prio;
        logic [7:0]  id;
    } t_entry;

    localparam int ENTRY_W   = $bits(t_entry);

endpackage

// ===== rtl/core/mdsq_ram.sv =====
// ----------------------------------------------------------------------------
// mdsq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mdsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/multilevel_deadline_sorted_queue_unit.sv =====
// ----------------------------------------------------------------------------
// multilevel_deadline_sorted_queue_unit
// One deadline-sorted task queue per importance level, kept in one RAM.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) carries one command per transfer: an
// enqueue of a new task or an update of the head deadline of a level.
// Output channel (o_valid / i_ready) returns one result per command: the
// level's head entry, its entry count and an error flag.
// The block takes one command at a time; o_ready is high only while the
// sequencer is idle. A sorted walk moves one entry at a time through the
// single RAM read port and the shared deadline comparator. o_ready returns
// as the result loads into the output register.
// The result sits in an output register; the next command is accepted while
// it waits. A stalled receiver holds the sequencer at its last step until the
// output register frees up.
// Reset clears the per-level counts and the handshake state; the entry RAM
// needs no clearing, since only entries below a level's count are read.
// ----------------------------------------------------------------------------
module multilevel_deadline_sorted_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [1:0]  i_level,
    input  logic [31:0] i_deadline,
    input  logic [7:0]  i_task_prio,
    input  logic [7:0]  i_task_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_head_valid,
    output logic [31:0] o_head_deadline,
    output logic [7:0]  o_head_prio,
    output logic [7:0]  o_head_id,
    output logic [3:0]  o_level_count,
    output logic        o_op_error
);

    import mdsq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_HEAD_RD  = 8'b0000_0010,
        S_HEAD_CAP = 8'b0000_0100,
        S_STEP     = 8'b0000_1000,
        S_CMP      = 8'b0001_0000,
        S_FIN_RD   = 8'b0010_0000,
        S_FIN_CAP  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt [LEVELS];
    logic [CNT_W-1:0]  n_cnt_val;
    logic              n_cnt_we;
    logic              r_o_valid, n_o_valid;

    logic              r_op, n_op;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [31:0]       r_dl, n_dl;
    logic [7:0]        r_prio, n_prio;
    logic [7:0]        r_id, n_id;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [SLOT_W-1:0] r_hole, n_hole;
    logic              r_err, n_err;
    t_entry            r_res, n_res;
    logic              r_res_valid, n_res_valid;

    t_entry            r_out, n_out;
    logic              r_out_hv, n_out_hv;
    logic [3:0]        r_out_cnt, n_out_cnt;
    logic              r_out_err, n_out_err;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_wslot;
    t_entry            ram_wdata;
    logic [SLOT_W-1:0] ram_rslot;
    logic [ENTRY_W-1:0] ram_rdata_raw;
    t_entry            ram_rdata;
    t_entry            new_entry;

    logic [LVL_W-1:0]  in_lvl;
    logic              lvl_ok;
    logic [CNT_W-1:0]  cur_n;
    logic              out_free;

    assign ram_rdata = t_entry'(ram_rdata_raw);
    assign new_entry = '{deadline: r_dl, prio: r_prio, id: r_id};
    assign in_lvl    = LVL_W'(i_level);
    assign lvl_ok    = int'(i_level) < LEVELS;
    assign cur_n     = r_cnt[in_lvl];
    assign out_free  = !r_o_valid || i_ready;

    mdsq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({r_lvl, ram_wslot}),
        .i_wdata (ram_wdata),
        .i_raddr ({r_lvl, ram_rslot}),
        .o_rdata (ram_rdata_raw)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_lvl       = r_lvl;
        n_dl        = r_dl;
        n_prio      = r_prio;
        n_id        = r_id;
        n_n         = r_n;
        n_hole      = r_hole;
        n_err       = r_err;
        n_res       = r_res;
        n_res_valid = r_res_valid;
        n_out       = r_out;
        n_out_hv    = r_out_hv;
        n_out_cnt   = r_out_cnt;
        n_out_err   = r_out_err;
        n_o_valid   = r_o_valid && !i_ready;
        n_cnt_we    = 1'b0;
        n_cnt_val   = cur_n + 1'b1;
        ram_we      = 1'b0;
        ram_wslot   = r_hole;
        ram_wdata   = new_entry;
        ram_rslot   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op   = i_op;
                    n_lvl  = in_lvl;
                    n_dl   = i_deadline;
                    n_prio = i_task_prio;
                    n_id   = i_task_id;
                    n_n    = cur_n;
                    n_err  = 1'b0;
                    if (!lvl_ok) begin
                        n_err       = 1'b1;
                        n_n         = '0;
                        n_res       = '0;
                        n_res_valid = 1'b0;
                        n_state     = S_DONE;
                    end else if (i_op == OP_ENQ) begin
                        if (cur_n >= CNT_W'(DEPTH)) begin
                            n_err   = 1'b1;
                            n_state = S_FIN_RD;
                        end else begin
                            n_hole   = SLOT_W'(cur_n);
                            n_n      = cur_n + 1'b1;
                            n_cnt_we = 1'b1;
                            n_state  = S_STEP;
                        end
                    end else begin
                        if (cur_n == '0) begin
                            n_err   = 1'b1;
                            n_state = S_FIN_RD;
                        end else begin
                            n_hole  = '0;
                            n_state = S_HEAD_RD;
                        end
                    end
                end
            end
            S_HEAD_RD: begin
                n_state = S_HEAD_CAP;
            end
            S_HEAD_CAP: begin
                n_prio  = ram_rdata.prio;
                n_id    = ram_rdata.id;
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_op == OP_ENQ) begin
                    if (r_hole == '0) begin
                        ram_we  = 1'b1;
                        n_state = S_FIN_RD;
                    end else begin
                        ram_rslot = SLOT_W'(r_hole - 1'b1);
                        n_state   = S_CMP;
                    end
                end else begin
                    if ((CNT_W'(r_hole) + 1'b1) == r_n) begin
                        ram_we  = 1'b1;
                        n_state = S_FIN_RD;
                    end else begin
                        ram_rslot = SLOT_W'(r_hole + 1'b1);
                        n_state   = S_CMP;
                    end
                end
            end
            S_CMP: begin
                ram_we = 1'b1;
                if (r_op == OP_ENQ) begin
                    if (ram_rdata.deadline > r_dl) begin
                        ram_wdata = ram_rdata;
                        n_hole    = SLOT_W'(r_hole - 1'b1);
                        n_state   = S_STEP;
                    end else begin
                        n_state   = S_FIN_RD;
                    end
                end else begin
                    if (ram_rdata.deadline <= r_dl) begin
                        ram_wdata = ram_rdata;
                        n_hole    = SLOT_W'(r_hole + 1'b1);
                        n_state   = S_STEP;
                    end else begin
                        n_state   = S_FIN_RD;
                    end
                end
            end
            S_FIN_RD: begin
                n_state = S_FIN_CAP;
            end
            S_FIN_CAP: begin
                n_res_valid = (r_n != '0);
                n_res       = (r_n != '0) ? ram_rdata : '0;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_hv  = r_res_valid;
                    n_out_cnt = 4'(r_n);
                    n_out_err = r_err;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (n_cnt_we) begin
                r_cnt[in_lvl] <= n_cnt_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_lvl       <= n_lvl;
        r_dl        <= n_dl;
        r_prio      <= n_prio;
        r_id        <= n_id;
        r_n         <= n_n;
        r_hole      <= n_hole;
        r_err       <= n_err;
        r_res       <= n_res;
        r_res_valid <= n_res_valid;
        r_out       <= n_out;
        r_out_hv    <= n_out_hv;
        r_out_cnt   <= n_out_cnt;
        r_out_err   <= n_out_err;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_head_valid    = r_out_hv;
    assign o_head_deadline = r_out.deadline;
    assign o_head_prio     = r_out.prio;
    assign o_head_id       = r_out.id;
    assign o_level_count   = r_out_cnt;
    assign o_op_error      = r_out_err;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_n <= CNT_W'(DEPTH)))
        else $error("level count above queue depth");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_STEP || r_state == S_CMP))
        else $error("entry write outside the sorted walk");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("command accepted while a walk is starting");

    a_hole_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (CNT_W'(r_hole) < r_n))
        else $error("insert slot outside the filled part of the level");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_valid && r_state == S_IDLE))
        else $error("finished result not presented");

endmodule
